>>> rtl/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg
// Types and constants shared by the scalar Kalman filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

  // Fixed-point format of estimate, measurement and variances.
  localparam int unsigned FRAC_BITS = 16;
  // The gain is always Q1.16.
  localparam int unsigned GAIN_BITS = 16;
  localparam int unsigned GAIN_W    = GAIN_BITS + 1;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // One quotient bit per divider step; the gain never exceeds 1.0.
  localparam int unsigned DIV_STEPS = GAIN_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;

  localparam logic [DATA_W-1:0] Q_RESET = DATA_W'((64'd1 << FRAC_BITS) / 64'd100);
  localparam logic [DATA_W-1:0] R_RESET = DATA_W'(64'd1 << FRAC_BITS);

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_BITS);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ld_in;     // capture measurement, form predicted covariance
    logic div_init;  // load divisor and first partial remainder
    logic div_step;  // one restoring division step
    logic ld_mul;    // register both products
    logic ld_out;    // update state and load the result register
  } skf_cmd_t;

endpackage

`default_nettype wire

>>> rtl/skf_ctrl.sv
// ----------------------------------------------------------------------------
// skf_ctrl
// Sequencer for one filter update: predict, divide, multiply, write back.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output skf_pkg::skf_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } state_e;

  state_e                          state_q;
  logic [skf_pkg::DIV_CNT_W-1:0]   cnt_q;
  logic                            out_valid_q;
  logic                            out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.ld_in    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.div_init = (state_q == ST_INIT);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.ld_mul   = (state_q == ST_MUL);
    cmd_o.ld_out   = (state_q == ST_FIN) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // The result register keeps its item until the receiver takes it.
      if ((state_q == ST_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_INIT;
          end
        end
        ST_INIT: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt_q == skf_pkg::DIV_CNT_W'(skf_pkg::DIV_STEPS - 1)) begin
            state_q <= ST_MUL;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_MUL: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/skf_datapath.sv
// ----------------------------------------------------------------------------
// skf_datapath
// Filter state, noise registers, serial gain divider and the two multipliers.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_datapath (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire skf_pkg::skf_cmd_t                    cmd_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [skf_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [skf_pkg::DATA_W-1:0]           cfg_data_i,
  input  wire logic signed [skf_pkg::DATA_W-1:0]    measurement_i,
  output logic signed [skf_pkg::DATA_W-1:0]         estimate_o,
  output logic [skf_pkg::GAIN_W-1:0]                kalman_gain_o
);

  localparam int unsigned DW  = skf_pkg::DATA_W;
  localparam int unsigned GW  = skf_pkg::GAIN_W;
  localparam int unsigned GB  = skf_pkg::GAIN_BITS;
  localparam int unsigned PXW = GW + 1 + DW + 1;   // signed gain x innovation
  localparam int unsigned PPW = GW + DW;

  // Noise registers and filter state.
  logic [DW-1:0]        q_q, r_q;
  logic signed [DW-1:0] x_q;
  logic [DW-1:0]        p_q;

  // Per-item working registers.
  logic signed [DW-1:0] z_q;
  logic [DW-1:0]        pp_q;
  logic [DW:0]          div_q;
  logic [DW:0]          rem_q;
  logic [GW-1:0]        dvd_q;
  logic [GW-1:0]        quo_q;
  logic signed [PXW-1:0] prod_x_q;
  logic [PPW-1:0]       prod_p_q;
  logic [GW-1:0]        gain_q;

  logic signed [DW-1:0] est_q;
  logic [GW-1:0]        gain_out_q;

  logic [DW:0]            pred_sum;
  logic [DW-1:0]          pred_sat;
  logic [DW+1:0]          trial;
  logic                   trial_ge;
  logic [GW-1:0]          gain_w;
  logic signed [DW:0]     innov;
  logic signed [GW:0]     gain_s;
  logic signed [DW+2:0]   delta;
  logic signed [DW+3:0]   x_sum;
  logic signed [DW-1:0]   x_new;

  // Predicted covariance saturates at the top of the unsigned range.
  assign pred_sum = {1'b0, p_q} + {1'b0, q_q};
  assign pred_sat = pred_sum[DW] ? '1 : pred_sum[DW-1:0];

  // Restoring division of pp * 2^16 by pp + r, one quotient bit per step.
  assign trial    = {rem_q, dvd_q[GW-1]};
  assign trial_ge = (trial >= {1'b0, div_q});

  // A zero divisor means pp is zero too; the gain is then defined as zero.
  assign gain_w = (div_q == '0) ? '0 : quo_q;

  assign innov  = (DW+1)'(z_q) - (DW+1)'(x_q);
  assign gain_s = {1'b0, gain_w};

  // Arithmetic shift of the product is the floor of the division by 2^16.
  assign delta = prod_x_q[PXW-1:GB];
  assign x_sum = (DW+4)'(x_q) + (DW+4)'(delta);

  always_comb begin
    if (x_sum > (DW+4)'(signed'({1'b0, {(DW-1){1'b1}}}))) begin
      x_new = {1'b0, {(DW-1){1'b1}}};
    end else if (x_sum < -(DW+4)'(signed'({1'b0, 1'b1, {(DW-1){1'b0}}}))) begin
      x_new = {1'b1, {(DW-1){1'b0}}};
    end else begin
      x_new = x_sum[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= skf_pkg::Q_RESET;
      r_q <= skf_pkg::R_RESET;
      x_q <= '0;
      p_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          skf_pkg::REG_PROCESS_NOISE:     q_q <= cfg_data_i;
          skf_pkg::REG_MEASUREMENT_NOISE: r_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.ld_out) begin
        x_q <= x_new;
        p_q <= prod_p_q[GB+DW-1:GB];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      z_q  <= measurement_i;
      pp_q <= pred_sat;
    end
    if (cmd_i.div_init) begin
      div_q <= {1'b0, pp_q} + {1'b0, r_q};
      // The top bits of the dividend are pp >> 1, already below the divisor.
      rem_q <= {2'b00, pp_q[DW-1:1]};
      dvd_q <= {pp_q[0], {(GW-1){1'b0}}};
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= trial_ge ? (DW+1)'(trial - {1'b0, div_q}) : trial[DW:0];
      dvd_q <= {dvd_q[GW-2:0], 1'b0};
      quo_q <= {quo_q[GW-2:0], trial_ge};
    end
    if (cmd_i.ld_mul) begin
      prod_x_q <= PXW'(gain_s * innov);
      prod_p_q <= PPW'((skf_pkg::GAIN_ONE - gain_w) * pp_q);
      gain_q   <= gain_w;
    end
    if (cmd_i.ld_out) begin
      est_q      <= x_new;
      gain_out_q <= gain_q;
    end
  end

  assign estimate_o    = est_q;
  assign kalman_gain_o = gain_out_q;

endmodule

`default_nettype wire

>>> rtl/scalar_kalman_filter_core.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter_core
// One-dimensional Kalman filter with unit state transition and observation.
// ----------------------------------------------------------------------------
// Usage:
//   Measurements enter on the in_valid_i / in_ready_o channel, one item per
//   handshake, as signed Q16.16 on measurement_i. Each item yields one result
//   item on out_valid_o / out_ready_i: the new estimate (signed Q16.16,
//   saturated) and the gain used (Q1.16, 65536 is 1.0).
//   The noise variances q and r are written through cfg_valid_i with
//   cfg_index_i 0 and 1; other indexes are ignored. cfg_ready_o is always
//   high. Write them only while no item is in flight.
//   One item is processed at a time: the next item is accepted only once the
//   previous one has passed the 17-step serial gain divider and has been
//   written back to the result register.
//   The result register holds one finished item. If the receiver stalls, the
//   next item is still accepted and computed, then waits in its last step
//   until the register frees up.
//   Reset sets q to 0.01, r to 1.0, and clears estimate and covariance.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_filter_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic signed [skf_pkg::DATA_W-1:0]    measurement_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed [skf_pkg::DATA_W-1:0]         estimate_o,
  output logic [skf_pkg::GAIN_W-1:0]                kalman_gain_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [skf_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [skf_pkg::DATA_W-1:0]           cfg_data_i
);

  skf_pkg::skf_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  skf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  skf_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .measurement_i (measurement_i),
    .estimate_o    (estimate_o),
    .kalman_gain_o (kalman_gain_o)
  );

endmodule

`default_nettype wire

>>> rtl/skf_checker.sv
// ----------------------------------------------------------------------------
// skf_checker
// Port-level checks on the scalar Kalman filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_o,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic [skf_pkg::DATA_W-1:0]        estimate_o,
  input wire logic [skf_pkg::GAIN_W-1:0]        kalman_gain_o
);

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(estimate_o)
      && $stable(kalman_gain_o))
    else $error("result changed while stalled");

  // The gain never exceeds 1.0.
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> kalman_gain_o <= skf_pkg::GAIN_ONE)
    else $error("gain above 1.0");

  // Once an item is taken, no second item is taken in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while busy");

  // A new result only appears while the block is busy with an item.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without work");

endmodule

bind scalar_kalman_filter_core skf_checker u_skf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .estimate_o    (estimate_o),
  .kalman_gain_o (kalman_gain_o)
);

`default_nettype wire

>>> test/scalar_kalman_filter_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scalar_kalman_filter_core_tb
// Self-checking bench for the scalar Kalman filter core. A short directed
// table covers the reset state, field extremes, unity and zero gain and
// covariance saturation. Random phases then sweep the noise registers
// while measurements partly track a drifting target. Every result item is checked
// against a bit-exact predictor, with random stalls on both channels.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_core_tb;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned NUM_PHASES   = 13;
  localparam int unsigned IDLE_PCT     = 22;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PRINT_CAP    = 50;

  // Indexes the block decodes to nothing.
  localparam logic [skf_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [skf_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam logic [skf_pkg::DATA_W-1:0]        U32_MAX = '1;
  localparam logic signed [skf_pkg::DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [skf_pkg::DATA_W-1:0] S32_MIN = 32'sh8000_0000;
  localparam longint                            EST_HI  = 64'sd2147483647;
  localparam longint                            EST_LO  = -64'sd2147483648;

  typedef struct packed {
    logic signed [skf_pkg::DATA_W-1:0] estimate;
    logic [skf_pkg::GAIN_W-1:0]        gain;
  } kf_result_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_MEAS, ROW_MEAS_KNOWN} row_kind_e;

  typedef struct packed {
    row_kind_e                     kind;
    logic [skf_pkg::CFG_IDX_W-1:0] index;
    logic [skf_pkg::DATA_W-1:0]    data;
    kf_result_t                    known;
  } plan_row_t;

  logic                                 clk_i;
  logic                                 rst_ni        = 1'b0;
  logic                                 in_valid_i    = 1'b0;
  logic                                 in_ready_o;
  logic signed [skf_pkg::DATA_W-1:0]    measurement_i = '0;
  logic                                 out_valid_o;
  logic                                 out_ready_i   = 1'b0;
  logic signed [skf_pkg::DATA_W-1:0]    estimate_o;
  logic [skf_pkg::GAIN_W-1:0]           kalman_gain_o;
  logic                                 cfg_valid_i   = 1'b0;
  logic                                 cfg_ready_o;
  logic [skf_pkg::CFG_IDX_W-1:0]        cfg_index_i   = '0;
  logic [skf_pkg::DATA_W-1:0]           cfg_data_i    = '0;

  // Predictor copy of the filter state and noise registers.
  logic signed [skf_pkg::DATA_W-1:0]    filt_estimate   = '0;
  logic [skf_pkg::DATA_W-1:0]           filt_covariance = '0;
  logic [skf_pkg::DATA_W-1:0]           noise_q         = skf_pkg::Q_RESET;
  logic [skf_pkg::DATA_W-1:0]           noise_r         = skf_pkg::R_RESET;
  logic signed [skf_pkg::DATA_W-1:0]    walk_target     = '0;

  kf_result_t                  expected_updates[$];
  bit                          gaps_on        = 1'b1;
  int unsigned                 mismatch_count = 0;
  int unsigned                 item_count     = 0;
  int unsigned                 result_count   = 0;
  int unsigned                 write_count    = 0;
  int unsigned                 cycle_count    = 0;

  scalar_kalman_filter_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .measurement_i (measurement_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .estimate_o    (estimate_o),
    .kalman_gain_o (kalman_gain_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // One filter iteration: predict covariance, form gain, correct, shrink.
  function automatic kf_result_t kalman_update(
      input logic signed [skf_pkg::DATA_W-1:0] z);
    logic [63:0] pred_cov;
    logic [63:0] divisor;
    logic [63:0] gain;
    longint      innov;
    longint      corr;
    longint      next_x;
    kf_result_t  res;
    pred_cov = {32'd0, filt_covariance} + {32'd0, noise_q};
    if (pred_cov > {32'd0, U32_MAX}) begin
      pred_cov = {32'd0, U32_MAX};
    end
    divisor = pred_cov + {32'd0, noise_r};
    gain = (divisor == 64'd0) ? 64'd0 : (pred_cov << skf_pkg::GAIN_BITS) / divisor;
    innov = longint'(z) - longint'(filt_estimate);
    // Arithmetic shift of the product rounds toward minus infinity.
    corr = (longint'(gain) * innov) >>> skf_pkg::GAIN_BITS;
    next_x = longint'(filt_estimate) + corr;
    if (next_x > EST_HI) begin
      next_x = EST_HI;
    end else if (next_x < EST_LO) begin
      next_x = EST_LO;
    end
    filt_estimate   = skf_pkg::DATA_W'(next_x);
    filt_covariance = skf_pkg::DATA_W'(
        (((64'd1 << skf_pkg::GAIN_BITS) - gain) * pred_cov) >> skf_pkg::GAIN_BITS);
    res.estimate = filt_estimate;
    res.gain     = skf_pkg::GAIN_W'(gain);
    return res;
  endfunction

  function automatic plan_row_t mk_row(input row_kind_e kind,
                                       input logic [skf_pkg::CFG_IDX_W-1:0] index,
                                       input logic [skf_pkg::DATA_W-1:0] data,
                                       input logic [skf_pkg::DATA_W-1:0] est,
                                       input logic [skf_pkg::GAIN_W-1:0] gain);
    plan_row_t row;
    row.kind           = kind;
    row.index          = index;
    row.data           = data;
    row.known.estimate = est;
    row.known.gain     = gain;
    return row;
  endfunction

  // A noisy drifting target, plus wide and small random values and extremes.
  function automatic logic signed [skf_pkg::DATA_W-1:0] pick_measurement();
    int unsigned sel;
    sel = $urandom_range(99, 0);
    walk_target = walk_target + ($signed($urandom_range(16384, 0)) - 8192);
    if (sel < 45) begin
      return walk_target + ($signed($urandom_range(65535, 0)) - 32768);
    end else if (sel < 75) begin
      return $urandom;
    end else if (sel < 85) begin
      case ($urandom_range(3, 0))
        0:       return S32_MAX;
        1:       return S32_MIN;
        2:       return '0;
        default: return U32_MAX;
      endcase
    end
    return $signed($urandom_range(524287, 0)) - 262144;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < PRINT_CAP) begin
      $display("MISMATCH %s at result %0d: got %h, expected %h",
               what, result_count, got, want);
    end
    mismatch_count++;
  endtask

  // Called in the time step of the previous acceptance, so valid is driven once.
  task automatic send_measurement(input logic signed [skf_pkg::DATA_W-1:0] z,
                                  input bit use_known, input kf_result_t known);
    kf_result_t predicted;
    if (gaps_on && $urandom_range(99, 0) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99, 0) < IDLE_PCT) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    measurement_i <= z;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = kalman_update(z);
    expected_updates.push_back(use_known ? known : predicted);
    item_count++;
  endtask

  task automatic wait_until_drained();
    while (expected_updates.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [skf_pkg::CFG_IDX_W-1:0] index,
                           input logic [skf_pkg::DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (index)
      skf_pkg::REG_PROCESS_NOISE:     noise_q = value;
      skf_pkg::REG_MEASUREMENT_NOISE: noise_r = value;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    write_count++;
  endtask

  always @(posedge clk_i) begin
    kf_result_t want;
    if (out_valid_o && out_ready_i) begin
      result_count++;
      if (expected_updates.size() == 0) begin
        report_mismatch("unexpected result item", {32'd0, estimate_o}, '0);
      end else begin
        want = expected_updates.pop_front();
        if (estimate_o !== want.estimate) begin
          report_mismatch("estimate", {32'd0, estimate_o}, {32'd0, want.estimate});
        end
        if (kalman_gain_o !== want.gain) begin
          report_mismatch("kalman_gain", {47'd0, kalman_gain_o}, {47'd0, want.gain});
        end
      end
    end
    out_ready_i <= !gaps_on || ($urandom_range(99, 0) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_updates.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    plan_row_t                  plan[$];
    logic [skf_pkg::DATA_W-1:0] q_pick;
    logic [skf_pkg::DATA_W-1:0] r_pick;

    // First item after reset: q = 0.01, r = 1.0, p = 0 gives gain 648, estimate 0.
    plan.push_back(mk_row(ROW_MEAS_KNOWN, '0, '0, '0, 17'd648));
    plan.push_back(mk_row(ROW_MEAS, '0, S32_MAX, '0, '0));
    plan.push_back(mk_row(ROW_MEAS, '0, S32_MIN, '0, '0));
    plan.push_back(mk_row(ROW_MEAS, '0, 32'h0001_0000, '0, '0));
    plan.push_back(mk_row(ROW_MEAS, '0, U32_MAX, '0, '0));
    plan.push_back(mk_row(ROW_MEAS, '0, 32'h5555_5555, '0, '0));
    plan.push_back(mk_row(ROW_MEAS, '0, 32'hAAAA_AAAA, '0, '0));
    // With r = 0 the gain is exactly 1.0 and the estimate jumps to z.
    plan.push_back(mk_row(ROW_WRITE, skf_pkg::REG_MEASUREMENT_NOISE, '0, '0, '0));
    plan.push_back(mk_row(ROW_WRITE, skf_pkg::REG_PROCESS_NOISE, 32'd1, '0, '0));
    plan.push_back(mk_row(ROW_MEAS_KNOWN, '0, S32_MAX, S32_MAX, skf_pkg::GAIN_ONE));
    plan.push_back(mk_row(ROW_MEAS_KNOWN, '0, S32_MIN, S32_MIN, skf_pkg::GAIN_ONE));
    plan.push_back(mk_row(ROW_MEAS_KNOWN, '0, 32'h1234_5678, 32'h1234_5678,
                          skf_pkg::GAIN_ONE));
    // Covariance is now 0; with q = 0 too the divisor is zero and nothing moves.
    plan.push_back(mk_row(ROW_WRITE, skf_pkg::REG_PROCESS_NOISE, '0, '0, '0));
    plan.push_back(mk_row(ROW_MEAS_KNOWN, '0, S32_MAX, 32'h1234_5678, '0));
    plan.push_back(mk_row(ROW_MEAS_KNOWN, '0, S32_MIN, 32'h1234_5678, '0));
    // Full-scale noise drives the predicted covariance into saturation.
    plan.push_back(mk_row(ROW_WRITE, skf_pkg::REG_PROCESS_NOISE, U32_MAX, '0, '0));
    plan.push_back(mk_row(ROW_WRITE, skf_pkg::REG_MEASUREMENT_NOISE, U32_MAX, '0, '0));
    plan.push_back(mk_row(ROW_MEAS, '0, S32_MAX, '0, '0));
    plan.push_back(mk_row(ROW_MEAS, '0, S32_MIN, '0, '0));
    plan.push_back(mk_row(ROW_MEAS, '0, '0, '0, '0));
    // Writes to undecoded indexes must leave q and r alone.
    plan.push_back(mk_row(ROW_WRITE, REG_SPARE_2, '0, '0, '0));
    plan.push_back(mk_row(ROW_WRITE, REG_SPARE_3, U32_MAX, '0, '0));
    plan.push_back(mk_row(ROW_MEAS, '0, 32'h5555_5555, '0, '0));
    plan.push_back(mk_row(ROW_WRITE, skf_pkg::REG_PROCESS_NOISE, '0, '0, '0));
    plan.push_back(mk_row(ROW_WRITE, skf_pkg::REG_MEASUREMENT_NOISE, 32'd1, '0, '0));
    plan.push_back(mk_row(ROW_MEAS, '0, 32'h0000_0001, '0, '0));
    plan.push_back(mk_row(ROW_MEAS, '0, 32'hFFFF_0000, '0, '0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        in_valid_i <= 1'b0;
        wait_until_drained();
        write_reg(plan[i].index, plan[i].data);
      end else begin
        send_measurement(plan[i].data, plan[i].kind == ROW_MEAS_KNOWN, plan[i].known);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      in_valid_i <= 1'b0;
      wait_until_drained();
      gaps_on = !(ph == 3 || ph == 4);
      case (ph % 7)
        0: begin
          q_pick = skf_pkg::Q_RESET;
          r_pick = skf_pkg::R_RESET;
        end
        1: begin
          q_pick = '0;
          r_pick = '0;
        end
        2: begin
          q_pick = U32_MAX;
          r_pick = U32_MAX;
        end
        3: begin
          q_pick = '0;
          r_pick = U32_MAX;
        end
        4: begin
          q_pick = U32_MAX;
          r_pick = '0;
        end
        5: begin
          q_pick = $urandom_range(32'h0002_0000, 0);
          r_pick = $urandom_range(32'h0004_0000, 0);
        end
        default: begin
          q_pick = $urandom;
          r_pick = $urandom;
        end
      endcase
      if ($urandom_range(1, 0) == 0) begin
        write_reg(skf_pkg::REG_PROCESS_NOISE, q_pick);
        write_reg(skf_pkg::REG_MEASUREMENT_NOISE, r_pick);
      end else begin
        write_reg(skf_pkg::REG_MEASUREMENT_NOISE, r_pick);
        write_reg(skf_pkg::REG_PROCESS_NOISE, q_pick);
      end
      if ($urandom_range(3, 0) == 0) begin
        write_reg($urandom_range(1, 0) ? REG_SPARE_2 : REG_SPARE_3, $urandom);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_measurement(pick_measurement(), 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;
    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d results for %0d measurements after %0d register writes.",
             result_count, item_count, write_count);
    $display("Swept zero and full-scale noise, unity and zero gain, covariance saturation.");
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/skf_pkg.sv
rtl/skf_ctrl.sv
rtl/skf_datapath.sv
rtl/scalar_kalman_filter_core.sv
rtl/skf_checker.sv
test/scalar_kalman_filter_core_tb.sv
